// File: hdl/wca_pkg.sv
// Shared types and constants for the weighted cache with aging.
`timescale 1ns / 1ps
package wca_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int KEY_W        = 32;
    localparam int HANDLE_W     = 32;
    localparam int WEIGHT_W     = 16;
    localparam int KEEP_W       = 5;
    localparam int COUNT_W      = 5;

    localparam logic [WEIGHT_W-1:0] ADD_WEIGHT = WEIGHT_W'(10);
    localparam logic [WEIGHT_W-1:0] HIT_BONUS  = WEIGHT_W'(2);
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_TRIM   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] image;
        logic [HANDLE_W-1:0] mask;
        logic [WEIGHT_W-1:0] weight;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic sort_step;
        logic sort_odd;
        logic finish;
    } wca_cmd_t;

    typedef struct packed {
        logic need_sort;
    } wca_stat_t;

endpackage

// File: hdl/weighted_cache_with_aging.sv
// Top level of the weighted cache with aging.
`timescale 1ns / 1ps
// Ordered store of up to CAPACITY entries (key, image, mask, weight) with
// lookup, add-at-head and trim. One beat in, one beat out, one operation at
// a time. Lookup, add, opcode 3 and a trim with nothing to sort pass through
// capture, execute in parallel over all entries, and result; the result is
// registered by the execute step. Trim of a non-empty store with a nonzero keep
// count runs CAPACITY odd-even transposition passes over the entry row, plus
// capture, decode, finish and result. A new beat is taken after the result
// beat leaves.
module weighted_cache_with_aging import wca_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [KEY_W-1:0]    s_key,
    input  logic [HANDLE_W-1:0] s_image_handle,
    input  logic [HANDLE_W-1:0] s_mask_handle,
    input  logic [KEEP_W-1:0]   s_keep_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic [HANDLE_W-1:0] m_image_out,
    output logic [HANDLE_W-1:0] m_mask_out,
    output logic [COUNT_W-1:0]  m_entry_count,
    output logic                m_dropped
);

    wca_cmd_t  cmd;
    wca_stat_t stat;

    wca_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    wca_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_opcode),
        .s_key          (s_key),
        .s_image_handle (s_image_handle),
        .s_mask_handle  (s_mask_handle),
        .s_keep_count   (s_keep_count),
        .m_hit          (m_hit),
        .m_image_out    (m_image_out),
        .m_mask_out     (m_mask_out),
        .m_entry_count  (m_entry_count),
        .m_dropped      (m_dropped)
    );

endmodule

// File: hdl/wca_datapath.sv
// Entry store, lookup compare, insert shift, sort network step and result register.
`timescale 1ns / 1ps
module wca_datapath import wca_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  wca_cmd_t            cmd,
    output wca_stat_t           stat,
    input  logic [1:0]          s_opcode,
    input  logic [KEY_W-1:0]    s_key,
    input  logic [HANDLE_W-1:0] s_image_handle,
    input  logic [HANDLE_W-1:0] s_mask_handle,
    input  logic [KEEP_W-1:0]   s_keep_count,
    output logic                m_hit,
    output logic [HANDLE_W-1:0] m_image_out,
    output logic [HANDLE_W-1:0] m_mask_out,
    output logic [COUNT_W-1:0]  m_entry_count,
    output logic                m_dropped
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

    entry_t              ent_reg   [CAPACITY];
    entry_t              ent_next  [CAPACITY];
    logic [CNT_W-1:0]    count_reg, count_next;
    op_t                 op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [HANDLE_W-1:0] img_reg, msk_reg;
    logic [KEEP_W-1:0]   keep_reg;

    logic                hit_reg, hit_next;
    logic [HANDLE_W-1:0] img_out_reg, img_out_next;
    logic [HANDLE_W-1:0] msk_out_reg, msk_out_next;
    logic                drop_reg, drop_next;
    logic [CNT_W-1:0]    cnt_out_reg, cnt_out_next;

    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] first;
    logic [CAPACITY-2:0] swap;
    logic [WEIGHT_W:0]   bumped;
    logic [CMP_W-1:0]    keep_ext, count_ext;

    assign stat.need_sort = (op_reg == OP_TRIM) && (count_reg != '0) && (keep_reg != '0);
    assign keep_ext  = CMP_W'(keep_reg);
    assign count_ext = CMP_W'(count_reg);

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = (CNT_W'(i) < count_reg) && (ent_reg[i].key == key_reg);
        end
        // isolate the lowest set bit: first match in order
        first = match & (~match + CAPACITY'(1));
        for (int i = 0; i < CAPACITY - 1; i++) begin
            swap[i] = ((i % 2) == 1) == cmd.sort_odd
                && (CNT_W'(i + 1) < count_reg)
                && (ent_reg[i].weight < ent_reg[i + 1].weight);
        end
    end

    always_comb begin
        ent_next     = ent_reg;
        count_next   = count_reg;
        hit_next     = hit_reg;
        img_out_next = img_out_reg;
        msk_out_next = msk_out_reg;
        drop_next    = drop_reg;
        cnt_out_next = cnt_out_reg;
        bumped       = '0;

        if (cmd.exec) begin
            hit_next     = 1'b0;
            img_out_next = '0;
            msk_out_next = '0;
            drop_next    = 1'b0;
            case (op_reg)
                OP_LOOKUP: begin
                    hit_next = |match;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (first[i]) begin
                            bumped = {1'b0, ent_reg[i].weight} + {1'b0, HIT_BONUS};
                            ent_next[i].weight = bumped[WEIGHT_W] ? WEIGHT_MAX
                                                                  : bumped[WEIGHT_W-1:0];
                            img_out_next = ent_reg[i].image;
                            msk_out_next = ent_reg[i].mask;
                        end
                    end
                end
                OP_ADD: begin
                    if (img_reg != '0) begin
                        if (count_reg >= CNT_W'(CAPACITY)) begin
                            drop_next = 1'b1;
                        end else begin
                            for (int i = 1; i < CAPACITY; i++) begin
                                ent_next[i] = ent_reg[i - 1];
                            end
                            ent_next[0] = '{key: key_reg, image: img_reg, mask: msk_reg,
                                            weight: ADD_WEIGHT};
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                OP_TRIM: begin
                    // sorting trims finish later; only the empty case lands here
                    if (keep_reg == '0) begin
                        count_next = '0;
                    end
                end
                default: begin
                end
            endcase
            cnt_out_next = count_next;
        end

        if (cmd.sort_step) begin
            // pairs of one pass never overlap, so each swap moves two slots
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (swap[i]) begin
                    ent_next[i]     = ent_reg[i + 1];
                    ent_next[i + 1] = ent_reg[i];
                end
            end
        end

        if (cmd.finish) begin
            if (keep_ext < count_ext) begin
                count_next = CNT_W'(keep_reg);
            end
            for (int i = 0; i < CAPACITY; i++) begin
                ent_next[i].weight = ent_reg[i].weight >> 1;
            end
            hit_next     = 1'b0;
            img_out_next = '0;
            msk_out_next = '0;
            drop_next    = 1'b0;
            cnt_out_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg     <= ent_next;
        hit_reg     <= hit_next;
        img_out_reg <= img_out_next;
        msk_out_reg <= msk_out_next;
        drop_reg    <= drop_next;
        cnt_out_reg <= cnt_out_next;
        if (cmd.capture) begin
            op_reg   <= op_t'(s_opcode);
            key_reg  <= s_key;
            img_reg  <= s_image_handle;
            msk_reg  <= s_mask_handle;
            keep_reg <= s_keep_count;
        end
    end

    assign m_hit         = hit_reg;
    assign m_image_out   = img_out_reg;
    assign m_mask_out    = msk_out_reg;
    assign m_dropped     = drop_reg;
    assign m_entry_count = COUNT_W'(cnt_out_reg);

endmodule

// File: hdl/wca_ctrl.sv
// Controller: sequences capture, execute, sort passes and result handoff.
`timescale 1ns / 1ps
module wca_ctrl import wca_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output wca_cmd_t  cmd,
    input  wca_stat_t stat
);

    localparam int PH_W = $clog2(CAPACITY);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_SORT   = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [PH_W-1:0]  phase_reg, phase_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.sort_odd = phase_reg[0];
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                phase_next = '0;
                if (stat.need_sort) begin
                    state_next = ST_SORT;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_SORT: begin
                // odd-even transposition: one pass per entry slot
                cmd.sort_step = 1'b1;
                phase_next    = phase_reg + PH_W'(1);
                if (phase_reg == PH_W'(CAPACITY - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

endmodule

// File: hdl/wca_checker.sv
// Port-level checks for the weighted cache with aging, bound to the top level.
`timescale 1ns / 1ps
module wca_checker import wca_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_hit,
    input logic [HANDLE_W-1:0] m_image_out,
    input logic [COUNT_W-1:0]  m_entry_count,
    input logic                m_dropped
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped before handoff");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_hit_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_dropped))
        else $error("hit and drop reported together");

    a_hit_image: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_image_out != '0 && m_entry_count != '0)
        else $error("hit on empty store or zero image handle");

endmodule

bind weighted_cache_with_aging wca_checker u_wca_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_hit         (m_hit),
    .m_image_out   (m_image_out),
    .m_entry_count (m_entry_count),
    .m_dropped     (m_dropped)
);
